// ----- rtl/tpq_pkg.sv -----
package tpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W = 6;
  localparam int TOTAL_W = 7;
  localparam int MS_PER_SECOND = 1000;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [2:0] K_INSERT = 3'd0;
  localparam logic [2:0] K_UPDATE = 3'd1;
  localparam logic [2:0] K_REMOVE = 3'd2;
  localparam logic [2:0] K_POP = 3'd3;
  localparam logic [2:0] K_TICK = 3'd4;

  typedef struct packed {
    logic latch;
    logic prep;
    logic exec;
    logic ins;
  } cmd_t;

  typedef struct packed {
    logic needs_ins;
  } stat_t;

endpackage

// ----- rtl/timeout_priority_queue_top.sv -----
// Timeout priority queue: a sorted row of (timeout ms, handle) cells whose
// smallest entry always sits in cell 0, so the head needs no search.
// Input channel: an item is taken on a rising edge with start high and busy
// low; in_kind selects insert, update, remove, pop or tick.
// Result channel: one beat per item, shown for exactly one cycle while
// out_strobe is high; the receiver cannot stall it.
// Sequencing: after acceptance the control steps through PREP and EXEC, and
// through INS for insert and update, then raises out_strobe on entering DONE;
// the beat is taken at the edge that ends DONE and busy falls at that same
// edge, so the next item is taken only after the previous beat.
// The steps are: latch, scale seconds to ms and compare handles in every cell,
// delete or pop or tick in every cell at once, then for insert and update the
// sorted insert, slotted at the boundary of the less-or-equal compares.
// Reset empties the queue at once; cell contents are not cleared.
module timeout_priority_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [22:0] in_timeout_seconds,
  input  logic [15:0] in_handle,
  input  logic [30:0] in_elapsed_ms,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [5:0]  out_position,
  output logic        out_popped_valid,
  output logic [31:0] out_popped_timeout,
  output logic [15:0] out_popped_handle,
  output logic        out_head_valid,
  output logic [31:0] out_head_timeout,
  output logic [15:0] out_head_handle,
  output logic [6:0]  out_entry_total
);

  tpq_pkg::cmd_t  cmd;
  tpq_pkg::stat_t stat;

  tpq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_strobe(out_strobe), .cmd(cmd), .stat(stat)
  );

  tpq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_kind(in_kind), .in_timeout_seconds(in_timeout_seconds),
    .in_handle(in_handle), .in_elapsed_ms(in_elapsed_ms),
    .out_status(out_status), .out_position(out_position),
    .out_popped_valid(out_popped_valid), .out_popped_timeout(out_popped_timeout),
    .out_popped_handle(out_popped_handle), .out_head_valid(out_head_valid),
    .out_head_timeout(out_head_timeout), .out_head_handle(out_head_handle),
    .out_entry_total(out_entry_total)
  );

endmodule

// ----- rtl/tpq_ctrl.sv -----
module tpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_strobe,
  output tpq_pkg::cmd_t cmd,
  input  tpq_pkg::stat_t stat
);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_EXEC, S_INS, S_DONE} state_t;

  state_t state_r;
  logic   strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: if (start) state_r <= S_PREP;
        S_PREP: state_r <= S_EXEC;
        S_EXEC: begin
          if (stat.needs_ins) begin
            state_r <= S_INS;
          end else begin
            state_r <= S_DONE;
            strobe_r <= 1'b1;
          end
        end
        S_INS: begin
          state_r <= S_DONE;
          strobe_r <= 1'b1;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign cmd.latch = (state_r == S_IDLE) && start;
  assign cmd.prep = (state_r == S_PREP);
  assign cmd.exec = (state_r == S_EXEC);
  assign cmd.ins = (state_r == S_INS);

endmodule

// ----- rtl/tpq_dp.sv -----
module tpq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tpq_pkg::cmd_t       cmd,
  output tpq_pkg::stat_t      stat,
  input  logic [2:0]          in_kind,
  input  logic [22:0]         in_timeout_seconds,
  input  logic [15:0]         in_handle,
  input  logic [30:0]         in_elapsed_ms,
  output logic [1:0]          out_status,
  output logic [5:0]          out_position,
  output logic                out_popped_valid,
  output logic [31:0]         out_popped_timeout,
  output logic [15:0]         out_popped_handle,
  output logic                out_head_valid,
  output logic [31:0]         out_head_timeout,
  output logic [15:0]         out_head_handle,
  output logic [6:0]          out_entry_total
);

  localparam int N = tpq_pkg::QUEUE_DEPTH;
  localparam int IW = tpq_pkg::IDX_W;
  localparam int CW = tpq_pkg::CNT_W;
  localparam int PW = tpq_pkg::POS_W;
  localparam int TW = tpq_pkg::TOTAL_W;

  logic [31:0]   t_r [N];
  logic [15:0]   h_r [N];
  logic [CW-1:0] count_r;
  logic [2:0]    kind_r;
  logic [22:0]   secs_r;
  logic [15:0]   handle_r;
  logic [30:0]   el_r;
  logic [31:0]   ms_r;
  logic [N-1:0]  match_r;
  logic [1:0]    status_r;
  logic [PW-1:0] pos_r;
  logic          pv_r;
  logic [31:0]   pt_r;
  logic [15:0]   ph_r;

  logic [32:0]   prod;
  logic [N-1:0]  valid;
  logic [N-1:0]  match;
  logic [N-1:0]  le;
  logic [N-1:0]  bnd;
  logic [N-1:0]  sfx;
  logic [N-1:0]  hit;
  logic [N-1:0]  del_mask;
  logic [IW-1:0] ins_idx;
  logic [CW-1:0] pos_diff;
  logic [PW+CW-1:0] pos_ext;
  logic [TW+CW-1:0] total_ext;

  assign prod = {10'd0, secs_r} * 33'(tpq_pkg::MS_PER_SECOND);

  always_comb begin
    for (int k = 0; k < N; k++) begin
      valid[k] = (CW'(k) < count_r);
      match[k] = valid[k] && (h_r[k] == handle_r);
      le[k] = valid[k] && (t_r[k] <= ms_r);
    end
    for (int k = 0; k < N; k++) begin
      if (k == 0) bnd[k] = !le[k];
      else bnd[k] = !le[k] && le[k-1];
    end
    ins_idx = '0;
    for (int k = 0; k < N; k++) begin
      if (bnd[k]) ins_idx = ins_idx | IW'(k);
    end
    sfx = match_r;
    for (int s = 1; s < N; s = s * 2) sfx = sfx | (sfx >> s);
    hit = match_r & ~(sfx >> 1);
    del_mask = hit;
    for (int s = 1; s < N; s = s * 2) del_mask = del_mask | (del_mask << s);
    pos_diff = count_r - CW'(ins_idx);
    pos_ext = {{PW{1'b0}}, pos_diff};
    total_ext = {{TW{1'b0}}, count_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      if (cmd.exec) begin
        case (kind_r)
          tpq_pkg::K_UPDATE, tpq_pkg::K_REMOVE: begin
            if (|match_r) count_r <= count_r - 1'b1;
          end
          tpq_pkg::K_POP: begin
            if (count_r != '0) count_r <= count_r - 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.ins && count_r != CW'(N)) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      secs_r <= in_timeout_seconds;
      handle_r <= in_handle;
      el_r <= in_elapsed_ms;
      status_r <= tpq_pkg::ST_OK;
      pos_r <= '0;
      pv_r <= 1'b0;
      pt_r <= '0;
      ph_r <= '0;
    end
    if (cmd.prep) begin
      ms_r <= prod[32] ? 32'hFFFF_FFFF : prod[31:0];
      match_r <= match;
    end
    if (cmd.exec) begin
      case (kind_r)
        tpq_pkg::K_UPDATE, tpq_pkg::K_REMOVE: begin
          for (int k = 0; k < N - 1; k++) begin
            if (del_mask[k]) begin
              t_r[k] <= t_r[k+1];
              h_r[k] <= h_r[k+1];
            end
          end
        end
        tpq_pkg::K_POP: begin
          if (count_r == '0) begin
            status_r <= tpq_pkg::ST_EMPTY;
          end else begin
            pv_r <= 1'b1;
            pt_r <= t_r[0];
            ph_r <= h_r[0];
            for (int k = 0; k < N - 1; k++) begin
              t_r[k] <= t_r[k+1];
              h_r[k] <= h_r[k+1];
            end
          end
        end
        tpq_pkg::K_TICK: begin
          for (int k = 0; k < N; k++) begin
            t_r[k] <= (t_r[k] >= {1'b0, el_r}) ? t_r[k] - {1'b0, el_r} : 32'd0;
          end
        end
        default: ;
      endcase
    end
    if (cmd.ins) begin
      if (count_r == CW'(N)) begin
        status_r <= tpq_pkg::ST_FULL;
      end else begin
        pos_r <= pos_ext[PW-1:0];
        for (int k = 0; k < N; k++) begin
          if (bnd[k]) begin
            t_r[k] <= ms_r;
            h_r[k] <= handle_r;
          end else if (!le[k] && k > 0) begin
            t_r[k] <= t_r[(k > 0) ? k - 1 : 0];
            h_r[k] <= h_r[(k > 0) ? k - 1 : 0];
          end
        end
      end
    end
  end

  assign stat.needs_ins = (kind_r == tpq_pkg::K_INSERT) || (kind_r == tpq_pkg::K_UPDATE);

  assign out_status = status_r;
  assign out_position = pos_r;
  assign out_popped_valid = pv_r;
  assign out_popped_timeout = pt_r;
  assign out_popped_handle = ph_r;
  assign out_head_valid = (count_r != '0);
  assign out_head_timeout = (count_r != '0) ? t_r[0] : 32'd0;
  assign out_head_handle = (count_r != '0) ? h_r[0] : 16'd0;
  assign out_entry_total = total_ext[TW-1:0];

endmodule

// ----- rtl/tpq_checker.sv -----
module tpq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic        out_popped_valid,
  input logic        out_head_valid,
  input logic [31:0] out_head_timeout,
  input logic [15:0] out_head_handle,
  input logic [6:0]  out_entry_total
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result beat lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result beat while idle");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_head_valid) |->
      (out_head_timeout == 32'd0 && out_head_handle == 16'd0 && out_entry_total == 7'd0))
    else $error("empty queue shows a head");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == tpq_pkg::ST_EMPTY) |-> (!out_popped_valid && !out_head_valid))
    else $error("empty pop returned an entry");

endmodule

bind timeout_priority_queue_top tpq_checker u_tpq_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe),
  .out_status(out_status), .out_popped_valid(out_popped_valid),
  .out_head_valid(out_head_valid), .out_head_timeout(out_head_timeout),
  .out_head_handle(out_head_handle), .out_entry_total(out_entry_total)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] K_BOGUS = 3'd7;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic        popped_valid;
    logic [31:0] popped_timeout;
    logic [15:0] popped_handle;
    logic        head_valid;
    logic [31:0] head_timeout;
    logic [15:0] head_handle;
    logic [6:0]  entry_total;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [22:0] in_timeout_seconds;
  logic [15:0] in_handle;
  logic [30:0] in_elapsed_ms;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [5:0]  out_position;
  logic        out_popped_valid;
  logic [31:0] out_popped_timeout;
  logic [15:0] out_popped_handle;
  logic        out_head_valid;
  logic [31:0] out_head_timeout;
  logic [15:0] out_head_handle;
  logic [6:0]  out_entry_total;

  logic [31:0] q_ms [tpq_pkg::QUEUE_DEPTH];
  logic [15:0] q_handle [tpq_pkg::QUEUE_DEPTH];
  int          q_count;
  verdict_t    pending_verdicts [$];
  int          mismatches;
  int          beats_checked;
  int          items_sent;
  int          cycle_count;
  int          idle_pct;

  timeout_priority_queue_top u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d beats still expected.", pending_verdicts.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic void drop_from_queue(logic [15:0] h);
    for (int i = 0; i < q_count; i++) begin
      if (q_handle[i] == h) begin
        for (int j = i; j + 1 < q_count; j++) begin
          q_ms[j] = q_ms[j + 1];
          q_handle[j] = q_handle[j + 1];
        end
        q_count--;
        return;
      end
    end
  endfunction

  function automatic verdict_t predict_queue_op(logic [2:0] kind, logic [22:0] secs,
                                                logic [15:0] h, logic [30:0] el);
    verdict_t v;
    logic [63:0] ms;
    logic [31:0] t;
    int i;
    v = '0;
    if (kind == tpq_pkg::K_INSERT || kind == tpq_pkg::K_UPDATE) begin
      if (kind == tpq_pkg::K_UPDATE) drop_from_queue(h);
      if (q_count >= tpq_pkg::QUEUE_DEPTH) begin
        v.status = tpq_pkg::ST_FULL;
      end else begin
        ms = 64'(secs) * 64'd1000;
        t = (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
        i = 0;
        while (i < q_count && q_ms[i] > t) i++;
        for (int s = q_count; s > i; s--) begin
          q_ms[s] = q_ms[s - 1];
          q_handle[s] = q_handle[s - 1];
        end
        q_ms[i] = t;
        q_handle[i] = h;
        q_count++;
        v.position = 6'(i);
      end
    end else if (kind == tpq_pkg::K_REMOVE) begin
      drop_from_queue(h);
    end else if (kind == tpq_pkg::K_POP) begin
      if (q_count == 0) begin
        v.status = tpq_pkg::ST_EMPTY;
      end else begin
        q_count--;
        v.popped_valid = 1'b1;
        v.popped_timeout = q_ms[q_count];
        v.popped_handle = q_handle[q_count];
      end
    end else if (kind == tpq_pkg::K_TICK) begin
      for (int k = 0; k < q_count; k++)
        q_ms[k] = (q_ms[k] >= 32'(el)) ? q_ms[k] - 32'(el) : 32'd0;
    end
    if (q_count > 0) begin
      v.head_valid = 1'b1;
      v.head_timeout = q_ms[q_count - 1];
      v.head_handle = q_handle[q_count - 1];
    end
    v.entry_total = 7'(q_count);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_strobe) begin
      got = '{out_status, out_position, out_popped_valid, out_popped_timeout,
              out_popped_handle, out_head_valid, out_head_timeout, out_head_handle,
              out_entry_total};
      beats_checked++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat: %p", got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic send_item(logic [2:0] kind, logic [22:0] secs, logic [15:0] h,
                           logic [30:0] el);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_timeout_seconds <= secs;
    in_handle <= h;
    in_elapsed_ms <= el;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_verdicts.push_back(predict_queue_op(kind, secs, h, el));
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(tpq_pkg::K_POP, 0, 0, 0);
    send_item(tpq_pkg::K_REMOVE, 0, 16'h1234, 0);
    send_item(tpq_pkg::K_INSERT, 23'h7FFFFF, 16'hFFFF, 0);
    send_item(tpq_pkg::K_INSERT, 0, 16'h0000, 0);
    send_item(tpq_pkg::K_INSERT, 4294967, 16'hAAAA, 0);
    send_item(tpq_pkg::K_INSERT, 4294968, 16'h5555, 0);
    send_item(tpq_pkg::K_INSERT, 5, 16'h0001, 0);
    send_item(tpq_pkg::K_INSERT, 5, 16'h0002, 0);
    send_item(tpq_pkg::K_UPDATE, 1, 16'h0001, 0);
    send_item(tpq_pkg::K_UPDATE, 9, 16'h0BAD, 0);
    send_item(tpq_pkg::K_TICK, 0, 0, 31'h7FFFFFFF);
    send_item(tpq_pkg::K_TICK, 0, 0, 0);
    send_item(K_BOGUS, 23'h7FFFFF, 16'hFFFF, 31'h7FFFFFFF);
    send_item(3'd5, 1, 1, 1);
    send_item(3'd6, 1, 1, 1);
    send_item(tpq_pkg::K_REMOVE, 0, 16'h0BAD, 0);
    send_item(tpq_pkg::K_POP, 0, 0, 0);
    send_item(tpq_pkg::K_TICK, 0, 0, 31'h2AAAAAAA);
    drain_results();
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < tpq_pkg::QUEUE_DEPTH + 2; i++)
      send_item(tpq_pkg::K_INSERT, 23'($urandom_range(50)), 16'($urandom_range(20)), 0);
    send_item(tpq_pkg::K_UPDATE, 3, 16'hBEEF, 0);
    send_item(tpq_pkg::K_UPDATE, 3, q_handle[0], 0);
    while (q_count > 0) send_item(tpq_pkg::K_POP, 0, 0, 0);
    send_item(tpq_pkg::K_POP, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_random(int n, int pct);
    logic [2:0] kind;
    logic [22:0] secs;
    logic [30:0] el;
    int r;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      kind = (r < 35) ? tpq_pkg::K_INSERT : (r < 50) ? tpq_pkg::K_UPDATE :
             (r < 65) ? tpq_pkg::K_REMOVE : (r < 82) ? tpq_pkg::K_POP :
             (r < 96) ? tpq_pkg::K_TICK : 3'($urandom_range(7, 5));
      secs = ($urandom_range(9) == 0) ? 23'($urandom) : 23'($urandom_range(1000));
      el = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(200000));
      send_item(kind, secs, ($urandom_range(3) == 0) ? 16'($urandom) :
                16'($urandom_range(40)), el);
    end
    drain_results();
    idle_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = '0;
    in_timeout_seconds = '0;
    in_handle = '0;
    in_elapsed_ms = '0;
    q_count = 0;
    mismatches = 0;
    beats_checked = 0;
    items_sent = 0;
    cycle_count = 0;
    idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_random(400, 0);
    test_random(400, 75);
    test_random(400, 0);
    test_random(400, 34);
    $display("Sent %0d items and checked %0d beats across directed, full-queue and",
             items_sent, beats_checked);
    $display("random phases with varied sender gaps; %0d mismatches.", mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
